>>> hdl/pclru_pkg.sv
// ----------------------------------------------------------------------------
// pclru_pkg
// Shared types and constants for the per-process LRU page cache.
// ----------------------------------------------------------------------------
package pclru_pkg;

   localparam int Entries   = 16;
   localparam int PageWords = 64;
   localparam int SlotW     = $clog2(Entries);
   localparam int OffW      = $clog2(PageWords);
   localparam int StoreD    = Entries * PageWords;
   localparam int StoreAw   = $clog2(StoreD);
   localparam int CntW      = $clog2(Entries + 1);

   typedef logic [1:0] mode_type;
   localparam mode_type ModeWrite = 2'd0;
   localparam mode_type ModeRead  = 2'd1;
   localparam mode_type ModeFlush = 2'd2;

   typedef logic [0:0] csr_idx_type;
   localparam csr_idx_type CsrEnabled = 1'd0;
   localparam csr_idx_type CsrMaxPer  = 1'd1;

   typedef enum logic [1:0] {
      StIdle,
      StStream,
      StResp
   } state_type;

endpackage

>>> hdl/pclru_ram.sv
// ----------------------------------------------------------------------------
// pclru_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pclru_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hdl/page_cache_lru_per_process.sv
// ----------------------------------------------------------------------------
// page_cache_lru_per_process
// Fully associative page cache tagged by process id and page, with LRU order.
// ----------------------------------------------------------------------------
// Timing: every write word, flush, miss or refusal presents its single
// response once the lookup result is registered and then the response
// register is loaded; the next transaction can be accepted the cycle after
// that response is taken. A read hit streams all 64 page words from the page
// store through its registered read port; a word is requested only when the
// response register is free, and each word is read from the store and loaded
// into the response register before the next word is requested. One
// transaction is in flight at a time; output stalls only delay the response
// and the next acceptance.
module page_cache_lru_per_process (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [7:0]                  req_pid,
   input  logic [15:0]                 req_page_number,
   input  logic [5:0]                  req_word_offset,
   input  logic [31:0]                 req_data_word,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_ok,
   output logic [31:0]                 rsp_read_word,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [31:0]                 csr_data
);
   import pclru_pkg::*;

   logic                enabled_ff;
   logic [4:0]          max_ff;
   logic [Entries-1:0]  valid_ff;
   logic [7:0]          owner_ff [Entries];
   logic [15:0]         tag_ff   [Entries];
   logic [SlotW-1:0]    order_ff [Entries];
   logic [SlotW-1:0]    wslot_ff;
   logic                wopen_ff;

   state_type           state_ff, state_in;
   logic [SlotW-1:0]    rslot_ff;
   logic [OffW:0]       rcnt_ff;      // words requested so far
   logic                rpend_ff;     // a RAM read returns this cycle
   logic                rlast_ff;

   logic                rsp_valid_ff;
   logic                rsp_ok_ff;
   logic [31:0]         rsp_word_ff;
   logic                rsp_last_ff;

   // ---------------- lookup (combinational over the tag registers)
   logic [CntW-1:0]     cnt;
   logic                whit, rhit, empty_found;
   logic [SlotW-1:0]    whit_slot, empty_slot;
   logic [SlotW-1:0]    rpos;
   logic [SlotW-1:0]    s;

   always_comb begin
      cnt = '0; whit = 1'b0; rhit = 1'b0; empty_found = 1'b0;
      whit_slot = '0; empty_slot = '0; rpos = '0; s = '0;
      for (int i = 0; i < Entries; i++) begin
         s = order_ff[i];
         if (valid_ff[s] && owner_ff[s] == req_pid) begin
            cnt = cnt + CntW'(1);
            if (!whit && tag_ff[s] == req_page_number) begin
               whit = 1'b1; whit_slot = s;
            end
            if (tag_ff[s] == req_page_number) begin
               rhit = 1'b1; rpos = SlotW'(i);
            end
         end
         if (!valid_ff[s] && !empty_found) begin
            empty_found = 1'b1; empty_slot = s;
         end
      end
   end

   // ---------------- page store
   logic                 ram_we;
   logic [StoreAw-1:0]   ram_waddr, ram_raddr;
   logic [31:0]          ram_rdata;

   pclru_ram #(.Width(32), .Depth(StoreD)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(req_data_word),
      .rd_addr(ram_raddr), .rd_data(ram_rdata)
   );

   logic acc, rsp_free, cont_ok, alloc;
   logic [SlotW-1:0] alloc_slot;

   assign req_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign acc       = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign cont_ok   = wopen_ff && (32'(req_word_offset) < PageWords);
   assign alloc     = !whit && (5'(cnt) != max_ff);
   assign alloc_slot = whit ? whit_slot : (empty_found ? empty_slot : order_ff[0]);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {wslot_ff, OffW'(req_word_offset)};
      if (acc && enabled_ff && req_mode == ModeWrite) begin
         if (req_word_offset != '0) begin
            ram_we = cont_ok;
         end else if (whit || alloc) begin
            ram_we    = 1'b1;
            ram_waddr = {alloc_slot, OffW'(0)};
         end
      end
      ram_raddr = {rslot_ff, rcnt_ff[OffW-1:0]};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: begin
            if (acc && enabled_ff && req_mode == ModeRead && rhit) state_in = StStream;
            else if (acc) state_in = StResp;
         end
         StStream: begin
            if (rlast_ff && rsp_valid_ff && rsp_ready && !rpend_ff) state_in = StIdle;
         end
         StResp: begin
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   logic okv;
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         max_ff     <= 5'd16;
         valid_ff   <= '0;
         for (int i = 0; i < Entries; i++) begin
            owner_ff[i] <= '0;
            tag_ff[i]   <= '0;
            order_ff[i] <= SlotW'(i);
         end
         wslot_ff     <= '0;
         wopen_ff     <= 1'b0;
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         rpend_ff     <= 1'b0;
         rlast_ff     <= 1'b0;
         rcnt_ff      <= '0;
         rslot_ff     <= '0;
         okv          <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == CsrEnabled) enabled_ff <= csr_data[0];
            else max_ff <= csr_data[4:0];
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (acc) begin
            okv <= 1'b0;
            if (enabled_ff) begin
               unique case (req_mode)
                  ModeWrite: begin
                     if (req_word_offset != '0) okv <= cont_ok;
                     else if (whit || alloc) begin
                        okv <= 1'b1;
                        valid_ff[alloc_slot] <= 1'b1;
                        owner_ff[alloc_slot] <= req_pid;
                        tag_ff[alloc_slot]   <= req_page_number;
                        wslot_ff <= alloc_slot;
                        wopen_ff <= 1'b1;
                     end else wopen_ff <= 1'b0;
                  end
                  ModeRead: begin
                     if (rhit) begin
                        for (int i = 0; i < Entries - 1; i++)
                           if (SlotW'(i) >= rpos) order_ff[i] <= order_ff[i+1];
                        order_ff[Entries-1] <= order_ff[rpos];
                        rslot_ff <= order_ff[rpos];
                        rcnt_ff  <= '0;
                        rlast_ff <= 1'b0;
                     end
                  end
                  ModeFlush: begin
                     okv <= 1'b1;
                     valid_ff <= '0;
                     wopen_ff <= 1'b0;
                  end
                  default: okv <= 1'b0;
               endcase
            end
         end
         if (state_ff == StResp) begin
            rsp_valid_ff <= 1'b1;
            rsp_ok_ff    <= okv;
            rsp_word_ff  <= '0;
            rsp_last_ff  <= 1'b1;
         end
         if (state_ff == StStream) begin
            // issue a read when the word can land in the response register
            rpend_ff <= 1'b0;
            if (rpend_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_ok_ff    <= 1'b1;
               rsp_word_ff  <= ram_rdata;
               rsp_last_ff  <= (rcnt_ff == (OffW+1)'(PageWords));
               rlast_ff     <= (rcnt_ff == (OffW+1)'(PageWords));
            end else if (!rlast_ff && rsp_free
                         && rcnt_ff != (OffW+1)'(PageWords)) begin
               rpend_ff <= 1'b1;
               rcnt_ff  <= rcnt_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != StIdle |-> !acc) else $error("accept while busy");
   a_resp_after: assert property (@(posedge clock) disable iff (reset)
      state_ff == StResp |=> rsp_valid) else $error("missing response");
   a_pend_one: assert property (@(posedge clock) disable iff (reset)
      rpend_ff |=> !rpend_ff) else $error("double read pending");
`endif
endmodule
